@@ src/itp_pkg.sv @@
// Shared types and codes for the infix-to-postfix converter.
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  // Token kinds on the request side
  localparam logic [2:0] CMD_OPERAND  = 3'd0;
  localparam logic [2:0] CMD_OPERATOR = 3'd1;
  localparam logic [2:0] CMD_COMMA    = 3'd2;
  localparam logic [2:0] CMD_RPAREN   = 3'd3;
  localparam logic [2:0] CMD_END      = 3'd4;

  // Operator kinds
  localparam logic [1:0] ARITY_PAREN  = 2'd0;
  localparam logic [1:0] ARITY_FUNC   = 2'd1;
  localparam logic [1:0] ARITY_UNARY  = 2'd2;
  localparam logic [1:0] ARITY_BINARY = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_OPERAND  = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  // One operator stack entry
  typedef struct packed {
    logic [1:0] arity;
    logic [3:0] prec;
    logic [7:0] code;
  } entry_t;

  // Commands from the sequencer to the stack
  typedef struct packed {
    logic   push;
    logic   pop;
    logic   refill;
    entry_t entry;
  } stk_ctl_t;

endpackage

@@ src/itp_stack.sv @@
// Operator stack: top-of-stack register over a memory with registered read.
module itp_stack #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
  localparam int CntW = $clog2(STACK_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  itp_pkg::stk_ctl_t ctl,
  output itp_pkg::entry_t  top,
  output logic [CntW-1:0]  count
);
  import itp_pkg::*;

  localparam int AddrW = $clog2(STACK_DEPTH);

  entry_t            mem [STACK_DEPTH];
  entry_t            mem_rd_r;
  entry_t            top_r;
  logic [CntW-1:0]   count_r;
  logic [CntW-1:0]   cnt_m1;
  logic [CntW-1:0]   cnt_m2;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr;

  // Entries below the top live in memory at 0 .. count-2
  assign cnt_m1  = count_r - CntW'(1);
  assign cnt_m2  = count_r - CntW'(2);
  assign wr_addr = cnt_m1[AddrW-1:0];
  assign rd_addr = cnt_m2[AddrW-1:0];

  // Spill the old top on push; fetch the next one below every cycle
  always_ff @(posedge clk) begin
    if (ctl.push && count_r != '0) begin
      mem[wr_addr] <= top_r;
    end
    mem_rd_r <= mem[rd_addr];
  end

  // Hold the top register and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      if (ctl.push) begin
        count_r <= count_r + CntW'(1);
      end else if (ctl.pop) begin
        count_r <= cnt_m1;
      end
    end
    if (ctl.push) begin
      top_r <= ctl.entry;
    end else if (ctl.refill) begin
      top_r <= mem_rd_r;
    end
  end

  assign top   = top_r;
  assign count = count_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop) && !(ctl.push && ctl.refill))
    else $error("conflicting stack commands");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> count_r != '0)
    else $error("pop on empty stack");

endmodule

@@ src/infix_to_postfix_converter.sv @@
// Top level: shunting-yard sequencer with result holding and output register.
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_valid/in_stall   | command, arity_class, precedence,
//          |           |                     | op_code, operand_value
//  out_    | result    | out_valid/out_stall | kind, code, value, error_code, last
//
// One request at a time. Each popped operator takes an emit step and a step
// to reload the top register from stack memory; a right paren that drops
// its left paren takes a pop step and a reload step as well.
// Output stalls hold the sequencer once the held result cannot move.
// Reset (rst_n low, synchronous) empties the stack; memory is not cleared.
// The next request is taken while the last result still waits on out_stall.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [1:0]  in_arity_class,
  input  logic [3:0]  in_precedence,
  input  logic [7:0]  in_op_code,
  input  logic [15:0] in_operand_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_code,
  output logic [15:0] out_value,
  output logic [1:0]  out_error_code,
  output logic        out_last
);
  import itp_pkg::*;

  localparam int CntW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_REFILL, S_TAIL, S_DONE} state_t;

  state_t          state_r, state_nxt;
  stk_ctl_t        stk_ctl;
  entry_t          stk_top;
  logic [CntW-1:0] stk_count;

  // Latched request
  logic [2:0]  cmd_r;
  logic [1:0]  arity_r;
  logic [3:0]  prec_r;
  logic [7:0]  code_r;
  logic [15:0] value_r;
  logic        fn_r;

  // Held result and output register
  logic        pend_v_r;
  logic [1:0]  pend_kind_r, pend_err_r;
  logic [7:0]  pend_code_r;
  logic [15:0] pend_value_r;
  logic        out_valid_r, out_last_r;
  logic [1:0]  out_kind_r, out_err_r;
  logic [7:0]  out_code_r;
  logic [15:0] out_value_r;

  logic        accept, out_free, slot_ok, empty, full;
  logic        emit, flush, fn_set;
  logic [1:0]  em_kind, em_err;
  logic [7:0]  em_code;
  logic [15:0] em_value;

  itp_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl),
    .top   (stk_top),
    .count (stk_count)
  );

  assign accept   = in_valid && state_r == S_IDLE;
  assign out_free = !out_valid_r || !out_stall;
  assign slot_ok  = !pend_v_r || out_free;
  assign empty    = stk_count == '0;
  assign full     = stk_count == CntW'(STACK_DEPTH);

  // Sequence one request: pop, push or emit one step per cycle, waiting while a result has no room
  always_comb begin
    state_nxt = state_r;
    stk_ctl   = '0;
    emit      = 1'b0;
    flush     = 1'b0;
    fn_set    = 1'b0;
    em_kind   = KIND_OPERAND;
    em_code   = '0;
    em_value  = '0;
    em_err    = ERR_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        case (cmd_r)
          CMD_OPERAND: begin
            if (slot_ok) begin
              emit      = 1'b1;
              em_value  = value_r;
              state_nxt = S_DONE;
            end
          end
          CMD_OPERATOR: begin
            if (arity_r == ARITY_BINARY && !empty && stk_top.arity != ARITY_PAREN &&
                stk_top.prec <= prec_r) begin
              if (slot_ok) begin
                emit        = 1'b1;
                em_kind     = KIND_OPERATOR;
                em_code     = stk_top.code;
                stk_ctl.pop = 1'b1;
                state_nxt   = S_REFILL;
              end
            end else if (full) begin
              if (slot_ok) begin
                emit      = 1'b1;
                em_kind   = KIND_ERROR;
                em_err    = ERR_OVERFLOW;
                state_nxt = S_DONE;
              end
            end else begin
              stk_ctl.push  = 1'b1;
              stk_ctl.entry = '{arity: arity_r, prec: prec_r, code: code_r};
              state_nxt     = S_DONE;
            end
          end
          CMD_COMMA: begin
            if (!empty && stk_top.arity != ARITY_PAREN) begin
              if (slot_ok) begin
                emit        = 1'b1;
                em_kind     = KIND_OPERATOR;
                em_code     = stk_top.code;
                stk_ctl.pop = 1'b1;
                state_nxt   = S_REFILL;
              end
            end else begin
              state_nxt = S_DONE;
            end
          end
          CMD_RPAREN: begin
            if (fn_r) begin
              // paren already dropped: emit a function sitting right below
              if (!empty && stk_top.arity == ARITY_FUNC) begin
                if (slot_ok) begin
                  emit        = 1'b1;
                  em_kind     = KIND_OPERATOR;
                  em_code     = stk_top.code;
                  stk_ctl.pop = 1'b1;
                  state_nxt   = S_TAIL;
                end
              end else begin
                state_nxt = S_DONE;
              end
            end else if (empty) begin
              if (slot_ok) begin
                emit      = 1'b1;
                em_kind   = KIND_ERROR;
                em_err    = ERR_UNMATCHED;
                state_nxt = S_DONE;
              end
            end else if (stk_top.arity != ARITY_PAREN) begin
              if (slot_ok) begin
                emit        = 1'b1;
                em_kind     = KIND_OPERATOR;
                em_code     = stk_top.code;
                stk_ctl.pop = 1'b1;
                state_nxt   = S_REFILL;
              end
            end else begin
              stk_ctl.pop = 1'b1;
              fn_set      = 1'b1;
              state_nxt   = S_REFILL;
            end
          end
          CMD_END: begin
            if (!empty) begin
              if (slot_ok) begin
                emit        = 1'b1;
                em_kind     = KIND_OPERATOR;
                em_code     = stk_top.code;
                stk_ctl.pop = 1'b1;
                state_nxt   = S_REFILL;
              end
            end else if (slot_ok) begin
              emit      = 1'b1;
              em_kind   = KIND_END;
              state_nxt = S_DONE;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_REFILL: begin
        stk_ctl.refill = 1'b1;
        state_nxt      = S_EVAL;
      end
      S_TAIL: begin
        stk_ctl.refill = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // release the held result as the last one of this request
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          flush     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, request, held result and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fn_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cmd_r   <= in_command;
        arity_r <= in_arity_class;
        prec_r  <= in_precedence;
        code_r  <= in_op_code;
        value_r <= in_operand_value;
        fn_r    <= 1'b0;
      end else if (fn_set) begin
        fn_r <= 1'b1;
      end
      // advance the held result into the output register
      if (flush || (emit && pend_v_r)) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= pend_kind_r;
        out_code_r  <= pend_code_r;
        out_value_r <= pend_value_r;
        out_err_r   <= pend_err_r;
        out_last_r  <= flush;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (emit) begin
        pend_v_r     <= 1'b1;
        pend_kind_r  <= em_kind;
        pend_code_r  <= em_code;
        pend_value_r <= em_value;
        pend_err_r   <= em_err;
      end else if (flush) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  assign in_stall       = state_r != S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_code       = out_code_r;
  assign out_value      = out_value_r;
  assign out_error_code = out_err_r;
  assign out_last       = out_last_r;

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("held result left over between requests");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!pend_v_r || !out_valid_r || !out_stall))
    else $error("result produced without room");
  a_stack_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (stk_ctl.push || stk_ctl.pop) |-> state_r == S_EVAL)
    else $error("stack changed outside evaluation");

endmodule

@@ bench/postfix_checker.sv @@
// Checker for the infix-to-postfix converter: predicts each request's results and compares them.
`timescale 1ns / 1ps
module postfix_checker #(
  parameter int DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [1:0]  in_arity_class,
  input  logic [3:0]  in_precedence,
  input  logic [7:0]  in_op_code,
  input  logic [15:0] in_operand_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_code,
  input  logic [15:0] out_value,
  input  logic [1:0]  out_error_code,
  input  logic        out_last,
  output int          fail_count,
  output int          results_due
);
  import itp_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  code;
    logic [15:0] value;
    logic [1:0]  err;
    logic        last;
  } postfix_tok_t;

  // Operator stack mirror
  entry_t       op_stk [DEPTH];
  int unsigned  stk_n;

  // Tokens still owed by the block, oldest first
  postfix_tok_t due_q[$];
  // Tokens caused by the request being predicted
  postfix_tok_t step_q[$];

  initial begin
    fail_count  = 0;
    results_due = 0;
    stk_n       = 0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t ns checker: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    end
  endtask

  function automatic void put_tok(logic [1:0] kind, logic [7:0] code, logic [15:0] value,
                                  logic [1:0] err);
    postfix_tok_t t;
    t.kind  = kind;
    t.code  = code;
    t.value = value;
    t.err   = err;
    t.last  = 1'b0;
    step_q.insert(step_q.size(), t);
  endfunction

  function automatic void pop_to_output();
    put_tok(KIND_OPERATOR, op_stk[stk_n - 1].code, 16'd0, ERR_NONE);
    stk_n--;
  endfunction

  function automatic void push_operator(entry_t e);
    if (stk_n >= DEPTH) begin
      put_tok(KIND_ERROR, 8'd0, 16'd0, ERR_OVERFLOW);
    end else begin
      op_stk[stk_n] = e;
      stk_n++;
    end
  endfunction

  // Convert one request into the postfix tokens it releases
  function automatic void predict_request(logic [2:0] cmd, logic [1:0] arity, logic [3:0] prec,
                                          logic [7:0] code, logic [15:0] value);
    entry_t e;
    e.arity = arity;
    e.prec  = prec;
    e.code  = code;
    step_q.delete();
    case (cmd)
      CMD_OPERAND: begin
        put_tok(KIND_OPERAND, 8'd0, value, ERR_NONE);
      end
      CMD_OPERATOR: begin
        if (arity == ARITY_BINARY) begin
          while (stk_n > 0 && op_stk[stk_n - 1].arity != ARITY_PAREN &&
                 op_stk[stk_n - 1].prec <= prec) begin
            pop_to_output();
          end
        end
        push_operator(e);
      end
      CMD_COMMA: begin
        while (stk_n > 0 && op_stk[stk_n - 1].arity != ARITY_PAREN) begin
          pop_to_output();
        end
      end
      CMD_RPAREN: begin
        while (stk_n > 0 && op_stk[stk_n - 1].arity != ARITY_PAREN) begin
          pop_to_output();
        end
        if (stk_n == 0) begin
          put_tok(KIND_ERROR, 8'd0, 16'd0, ERR_UNMATCHED);
        end else begin
          // drop the paren, then release a function sitting right below it
          stk_n--;
          if (stk_n > 0 && op_stk[stk_n - 1].arity == ARITY_FUNC) begin
            pop_to_output();
          end
        end
      end
      CMD_END: begin
        while (stk_n > 0) begin
          pop_to_output();
        end
        put_tok(KIND_END, 8'd0, 16'd0, ERR_NONE);
      end
      default: begin
      end
    endcase
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].last = 1'b1;
    end
    foreach (step_q[i]) begin
      due_q.insert(due_q.size(), step_q[i]);
    end
  endfunction

  task automatic check_result();
    postfix_tok_t want;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: kind %0d code %0h value %0h error %0d",
                                out_kind, out_code, out_value, out_error_code));
    end else begin
      want = due_q.pop_front();
      check_field("kind", 16'(out_kind), 16'(want.kind));
      check_field("code", 16'(out_code), 16'(want.code));
      check_field("value", out_value, want.value);
      check_field("error_code", 16'(out_error_code), 16'(want.err));
      check_field("last", 16'(out_last), 16'(want.last));
    end
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      stk_n = 0;
      due_q.delete();
    end else begin
      // compare a result leaving the block
      if (out_valid && !out_stall) begin
        check_result();
      end
      // predict a request entering the block
      if (in_valid && !in_stall) begin
        predict_request(in_command, in_arity_class, in_precedence, in_op_code,
                        in_operand_value);
      end
    end
    results_due = due_q.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the converter testbench: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import itp_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 30;

  // Commands the block ignores
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command       = '0;
  logic [1:0]  in_arity_class   = '0;
  logic [3:0]  in_precedence    = '0;
  logic [7:0]  in_op_code       = '0;
  logic [15:0] in_operand_value = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_code;
  logic [15:0] out_value;
  logic [1:0]  out_error_code;
  logic        out_last;

  int fail_count;
  int results_due;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off      = 1'b0;
  int req_sent      = 0;
  int quiet_cycles  = 0;

  always #1 clk = ~clk;

  infix_to_postfix_converter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_arity_class   (in_arity_class),
    .in_precedence    (in_precedence),
    .in_op_code       (in_op_code),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_code         (out_code),
    .out_value        (out_value),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

  postfix_checker #(
    .DEPTH (STACK_DEPTH_DEF)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_arity_class   (in_arity_class),
    .in_precedence    (in_precedence),
    .in_op_code       (in_op_code),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_code         (out_code),
    .out_value        (out_value),
    .out_error_code   (out_error_code),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .results_due      (results_due)
  );

  // Stall the result side at random, or hold it off for a long stretch on demand
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic offer_req(logic [2:0] cmd, logic [1:0] arity, logic [3:0] prec,
                           logic [7:0] code, logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid         <= 1'b0;
      in_command       <= 3'($urandom_range(7));
      in_arity_class   <= 2'($urandom_range(3));
      in_precedence    <= 4'($urandom_range(15));
      in_op_code       <= 8'($urandom_range(255));
      in_operand_value <= 16'($urandom_range(65535));
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_arity_class   <= arity;
    in_precedence    <= prec;
    in_op_code       <= code;
    in_operand_value <= value;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    @(negedge clk);
    if (cmd <= CMD_END) begin
      req_sent++;
    end
  endtask

  task automatic put_operand(logic [15:0] value);
    offer_req(CMD_OPERAND, 2'($urandom_range(3)), 4'($urandom_range(15)),
              8'($urandom_range(255)), value);
  endtask

  task automatic put_op(logic [1:0] arity, logic [3:0] prec);
    offer_req(CMD_OPERATOR, arity, prec, 8'($urandom_range(255)),
              16'($urandom_range(65535)));
  endtask

  task automatic put_mark(logic [2:0] cmd);
    offer_req(cmd, 2'($urandom_range(3)), 4'($urandom_range(15)), 8'($urandom_range(255)),
              16'($urandom_range(65535)));
  endtask

  task automatic send_noise();
    offer_req(3'($urandom_range(7)), 2'($urandom_range(3)), 4'($urandom_range(15)),
              8'($urandom_range(255)), 16'($urandom_range(65535)));
  endtask

  // Send one well-formed expression with nesting, function calls and argument lists
  task automatic send_expression(int max_tokens);
    bit in_func [0:15];
    int depth;
    int n;
    int r;
    bit want_operand;
    bit done;
    depth        = 0;
    n            = 0;
    want_operand = 1'b1;
    done         = 1'b0;
    in_func[0]   = 1'b0;
    while (!done) begin
      r = $urandom_range(99);
      if (want_operand) begin
        if (n < max_tokens && depth < 15 && r < 14) begin
          put_op(ARITY_PAREN, 4'($urandom_range(15)));
          depth++;
          in_func[depth] = 1'b0;
        end else if (n < max_tokens && depth < 15 && r < 26) begin
          put_op(ARITY_FUNC, 4'($urandom_range(15)));
          put_op(ARITY_PAREN, 4'($urandom_range(15)));
          depth++;
          in_func[depth] = 1'b1;
        end else if (n < max_tokens && r < 36) begin
          put_op(ARITY_UNARY, 4'($urandom_range(15)));
        end else begin
          put_operand(16'($urandom_range(65535)));
          want_operand = 1'b0;
        end
      end else if (n >= max_tokens) begin
        // close whatever is open, then finish
        if (depth > 0) begin
          put_mark(CMD_RPAREN);
          depth--;
        end else begin
          put_mark(CMD_END);
          done = 1'b1;
        end
      end else if (r < 50) begin
        put_op(ARITY_BINARY, 4'($urandom_range(15)));
        want_operand = 1'b1;
      end else if (r < 62 && depth > 0 && in_func[depth]) begin
        put_mark(CMD_COMMA);
        want_operand = 1'b1;
      end else if (r < 85 && depth > 0) begin
        put_mark(CMD_RPAREN);
        depth--;
      end else if (r >= 85 && depth == 0) begin
        put_mark(CMD_END);
        done = 1'b1;
      end else begin
        put_op(ARITY_BINARY, 4'($urandom_range(15)));
        want_operand = 1'b1;
      end
      n++;
    end
  endtask

  // Mix expressions with stray tokens until enough requests have gone in
  task automatic run_random(int items);
    int goal;
    goal = req_sent + items;
    while (req_sent < goal) begin
      if ($urandom_range(99) < 75) begin
        send_expression($urandom_range(3, 14));
      end else begin
        repeat ($urandom_range(1, 3)) send_noise();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 88;

    // operand extremes and ignored commands
    put_operand(16'h0000);
    put_operand(16'hffff);
    put_mark(CMD_UNUSED_LO);
    put_mark(CMD_UNUSED_HI);
    // right paren and comma on an empty stack
    put_mark(CMD_RPAREN);
    put_mark(CMD_COMMA);
    // silent push, tighter binary, then an equal-precedence pop
    offer_req(CMD_OPERATOR, ARITY_UNARY, 4'd15, 8'hff, 16'h0000);
    offer_req(CMD_OPERATOR, ARITY_BINARY, 4'd0, 8'h00, 16'hffff);
    put_op(ARITY_BINARY, 4'd15);
    put_mark(CMD_END);
    // function call: comma flushes a binary, right paren releases the function
    put_op(ARITY_FUNC, 4'($urandom_range(15)));
    put_op(ARITY_PAREN, 4'($urandom_range(15)));
    put_operand(16'($urandom_range(65535)));
    put_op(ARITY_BINARY, 4'($urandom_range(15)));
    put_operand(16'($urandom_range(65535)));
    put_mark(CMD_COMMA);
    put_operand(16'($urandom_range(65535)));
    put_mark(CMD_RPAREN);
    put_mark(CMD_END);
    // binary stops at a paren; second right paren is unmatched
    put_op(ARITY_PAREN, 4'($urandom_range(15)));
    put_op(ARITY_BINARY, 4'd0);
    put_mark(CMD_RPAREN);
    put_mark(CMD_RPAREN);
    put_mark(CMD_END);

    run_random(RANDOM_ITEMS / 3);

    send_idle_pct = 88;
    recv_idle_pct = 35;
    run_random(RANDOM_ITEMS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // overfill the stack, then flush it all in one request
    repeat (STACK_DEPTH_DEF + 2) put_op(2'($urandom_range(2)), 4'($urandom_range(15)));
    put_mark(CMD_END);
    // hold off results while requests keep coming so the block backs up
    hold_off = 1'b1;
    repeat (12) put_operand(16'($urandom_range(65535)));
    put_mark(CMD_END);
    run_random(RANDOM_ITEMS / 3);

    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
